### hw/rtl/elgamal_signature_verify_macros.svh
// Assertion macros shared by the checker file.
`ifndef ELGAMAL_SIGNATURE_VERIFY_MACROS_SVH
`define ELGAMAL_SIGNATURE_VERIFY_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define EGV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define EGV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/egv_pkg.sv
// ----------------------------------------------------------------------------
// egv_pkg
// Shared types and constants for the signature check block.
// ----------------------------------------------------------------------------
package egv_pkg;
  localparam int MOD_BITS_DEF = 32;
  localparam int DATA_W = 32;
  localparam int EXP_BITS = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_MODULUS = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GENERATOR = 3'd4;
  localparam logic [DATA_W-1:0] MODULUS_RST = 32'd23;
  localparam logic [DATA_W-1:0] GENERATOR_RST = 32'd5;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] sig_first;
    logic [31:0] sig_second;
    logic [31:0] public_key;
  } in_item_t;

  typedef struct packed {
    logic [31:0] lhs_value;
    logic [31:0] rhs_value;
    logic        valid_res;
  } out_item_t;

  // request from the sequencer to the modular multiplier
  typedef struct packed {
    logic start;
  } mul_ctl_t;
endpackage

### hw/rtl/egv_modmul.sv
// ----------------------------------------------------------------------------
// egv_modmul
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module egv_modmul #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  egv_pkg::mul_ctl_t   ctl,
  input  logic [W-1:0]        x,
  input  logic [W-1:0]        y,
  input  logic [W-1:0]        m,
  output logic                done,
  output logic [W-1:0]        prod
);
  import egv_pkg::*;

  logic         busy;
  logic [W-1:0] acc;
  logic [W-1:0] xs;
  logic [W-1:0] ys;
  logic [W-1:0] acc_next;
  logic [W-1:0] xs_next;

  // (u + v) mod m with u, v < m, no overflow
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] mm);
    logic [W-1:0] gap;
    begin
      gap = mm - v;
      add_mod = (u >= gap) ? (u - gap) : (u + v);
    end
  endfunction

  always_comb begin
    acc_next = ys[0] ? add_mod(acc, xs, m) : acc;
    xs_next = add_mod(xs, xs, m);
  end

  assign done = busy && (ys == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
    if (ctl.start) begin
      acc <= '0;
      xs <= x;
      ys <= y;
    end else if (busy && ys != '0) begin
      acc <= acc_next;
      xs <= xs_next;
      ys <= ys >> 1;
    end
  end
endmodule

### hw/rtl/elgamal_signature_verify.sv
// ----------------------------------------------------------------------------
// elgamal_signature_verify
// ElGamal signature check: y^a * a^b mod p against g^m mod p.
// ----------------------------------------------------------------------------
// Channel  Signals                              Payload
// in       in_valid / in_ready / in_item        hash_value sig_first sig_second public_key
// out      out_valid / out_ready / out_item     lhs_value rhs_value valid_res
// cfg      psel penable pwrite paddr pwdata     modulus (0x0), generator (0x4)
//
// Each of the three powers first reduces its base mod p, then per exponent
// bit tests the bit, does a multiply when it is set and a square (none after
// the top bit). A multiply in the shared egv_modmul runs through issue,
// start, one multiplier bit per cycle (up to 32 bits) and done. A zero
// modulus returns on the next cycle. Reset is synchronous; after it the
// block is ready at once. The result sits in an output register; in_ready
// stays low until it is taken.
module elgamal_signature_verify #(
  parameter int MOD_BITS = egv_pkg::MOD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  egv_pkg::in_item_t       in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output egv_pkg::out_item_t      out_item,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [egv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import egv_pkg::*;

  localparam int W = MOD_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;  // reduce bases mod p
  localparam logic [3:0] S_MUL   = 4'd2;  // acc *= sq when exponent bit set
  localparam logic [3:0] S_SQR   = 4'd3;  // sq *= sq
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_NEXTP = 4'd5;  // finish one power
  localparam logic [3:0] S_FIN   = 4'd6;  // lhs = pow0 * pow1
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [31:0] modulus;
  logic [31:0] generator;
  logic [3:0]  state;
  logic [3:0]  ret;        // state to take after the multiplier finishes
  logic [1:0]  pidx;       // which power: 0 y^a, 1 a^b, 2 g^m
  logic [5:0]  bitn;
  logic [W-1:0] p;
  logic [W-1:0] acc;
  logic [W-1:0] sq;
  logic [31:0]  ex;
  logic [W-1:0] pw0;
  logic [W-1:0] pw1;
  logic [W-1:0] pw2;
  in_item_t     item;
  // reduction by shift-subtract: base mod p, one bit per cycle
  logic [W:0]   rem;
  logic [31:0]  rsrc;
  logic [5:0]   rcnt;
  logic [W:0]   rem_sh;

  mul_ctl_t     mctl;
  logic         mstart_next;
  logic [W-1:0] mx;
  logic [W-1:0] my;
  logic         mdone;
  logic [W-1:0] mprod;

  egv_modmul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .ctl(mctl), .x(mx), .y(my), .m(p),
    .done(mdone), .prod(mprod)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODULUS) ? modulus :
                  (paddr == REG_GENERATOR) ? generator : 32'd0;
  assign in_ready = (state == S_IDLE) && !out_valid;

  assign rem_sh = {rem[W-1:0], rsrc[31]};

  // pulse the multiplier start in the cycle after an issue state
  always_comb begin
    case (state)
      S_MUL: begin mstart_next = ex[0]; end
      S_SQR: begin mstart_next = (bitn != 6'd31); end
      S_FIN: begin mstart_next = 1'b1; end
      default: begin mstart_next = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RST;
      generator <= GENERATOR_RST;
      state <= S_IDLE;
      out_valid <= 1'b0;
      mctl.start <= 1'b0;
    end else begin
      mctl.start <= mstart_next;
      if (psel && penable && pwrite) begin
        if (paddr == REG_MODULUS) modulus <= pwdata;
        else if (paddr == REG_GENERATOR) generator <= pwdata;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_item;
            p <= W'(modulus);
            pidx <= 2'd0;
            rem <= '0;
            rsrc <= in_item.public_key;
            rcnt <= 6'd0;
            if (W'(modulus) == '0) begin
              // no residue ring: return zeros, never accepted
              out_item <= '0;
              out_valid <= 1'b1;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          // restoring remainder step
          if (rem_sh >= {1'b0, p}) rem <= rem_sh - {1'b0, p};
          else rem <= rem_sh;
          rsrc <= rsrc << 1;
          rcnt <= rcnt + 6'd1;
          if (rcnt == 6'd31) begin
            sq <= (rem_sh >= {1'b0, p}) ? W'(rem_sh - {1'b0, p}) : W'(rem_sh);
            acc <= (p == W'(1)) ? '0 : W'(1);
            case (pidx)
              2'd0: begin ex <= item.sig_first; end
              2'd1: begin ex <= item.sig_second; end
              default: begin ex <= item.hash_value; end
            endcase
            bitn <= 6'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (ex[0]) begin
            mx <= acc;
            my <= sq;
            ret <= S_MUL;
            ex[0] <= 1'b0;
            state <= S_WAIT;
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          ex <= ex >> 1;
          bitn <= bitn + 6'd1;
          if (bitn == 6'd31) begin
            state <= S_NEXTP;
          end else begin
            mx <= sq;
            my <= sq;
            ret <= S_SQR;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mdone && !mctl.start) begin
            if (ret == S_SQR) begin
              sq <= mprod;
              state <= S_MUL;
            end else if (ret == S_FIN) begin
              out_item.lhs_value <= 32'(mprod);
              out_item.rhs_value <= 32'(pw2);
              out_item.valid_res <= (mprod == pw2);
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              acc <= mprod;
              state <= S_SQR;
            end
          end
        end
        S_NEXTP: begin
          case (pidx)
            2'd0: begin pw0 <= acc; end
            2'd1: begin pw1 <= acc; end
            default: begin pw2 <= acc; end
          endcase
          if (pidx == 2'd2) begin
            state <= S_FIN;
          end else begin
            pidx <= pidx + 2'd1;
            rem <= '0;
            rsrc <= (pidx == 2'd0) ? item.sig_first : generator;
            rcnt <= 6'd0;
            state <= S_RED;
          end
        end
        S_FIN: begin
          mx <= pw0;
          my <= pw1;
          ret <= S_FIN;
          state <= S_WAIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

### hw/rtl/egv_checker.sv
// ----------------------------------------------------------------------------
// egv_checker
// Port-level checks on the signature check block.
// ----------------------------------------------------------------------------
`include "elgamal_signature_verify_macros.svh"
module egv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input egv_pkg::out_item_t out_item,
  input logic               pready
);
  import egv_pkg::*;

  `EGV_ASSERT_IMPL(a_flag_eq, clk, rst, out_valid && out_item.valid_res, out_item.lhs_value == out_item.rhs_value, "flag set on unequal values")
  `EGV_ASSERT_IMPL(a_no_take, clk, rst, out_valid, !in_ready, "input taken while result waits")
  `EGV_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")
  `EGV_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped")
  `EGV_ASSERT_IMPL(a_pready, clk, rst, 1'b1, pready, "pready low")
endmodule

bind elgamal_signature_verify egv_checker u_egv_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item), .pready(pready)
);
